FILE: design/pol_pkg.sv
package pol_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    POL_ALWAYS  = 2'd0,
    POL_ABSENT  = 2'd1,
    POL_PRESENT = 2'd2,
    POL_ALT     = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_INSERT,
    UPD_REMOVE
  } upd_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [1:0]  policy;
    logic        [15:0] object_id;
    logic signed [31:0] prio_in;
    logic        [4:0]  position;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [15:0] object_out;
    logic signed [31:0] prio_out;
    logic        [5:0]  entry_count;
  } out_item_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic      eval_en;
    logic      upd_en;
    upd_mode_t mode;
  } cell_ctl_t;

endpackage

FILE: design/pol_cell.sv
module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int OBJ_W  = 16,
  parameter int PRIO_W = 32,
  parameter int CNT_W  = 6
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [OBJ_W-1:0]  req_obj,
  input  logic [PRIO_W-1:0] req_prio,
  input  logic [4:0]        req_pos,
  input  logic [CNT_W-1:0]  count,
  // neighbor toward the head
  input  logic [OBJ_W-1:0]  left_obj,
  input  logic [PRIO_W-1:0] left_prio,
  input  logic              fb_in,
  input  logic              ib_in,
  input  logic [OBJ_W-1:0]  rd_obj_in,
  input  logic [PRIO_W-1:0] rd_prio_in,
  // neighbor toward the tail
  input  logic [OBJ_W-1:0]  right_obj,
  input  logic [PRIO_W-1:0] right_prio,
  input  logic              gx_right,
  output logic [OBJ_W-1:0]  obj_q,
  output logic [PRIO_W-1:0] prio_q,
  output logic              gx_q,
  output logic              fb_out,
  output logic              ib_out,
  output logic [OBJ_W-1:0]  rd_obj_out,
  output logic [PRIO_W-1:0] rd_prio_out,
  output logic              match
);

  logic [OBJ_W-1:0]  obj_r, obj_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              m_r, gx_r, hit_r;
  logic              occupied, gt;
  logic              f_lt, f_le, i_lt, i_le, i_le_next;

  assign occupied = IDX < int'(count);
  assign gt       = $signed(req_prio) > $signed(prio_r);
  assign match    = occupied && (obj_r == req_obj);

  // prefix flags along the chain: first match and insertion point
  assign f_lt      = fb_in;
  assign f_le      = fb_in | m_r;
  assign i_lt      = ib_in;
  assign i_le      = ib_in | gx_r;
  assign i_le_next = i_le | gx_right;

  assign fb_out      = f_le;
  assign ib_out      = i_le;
  assign obj_q       = obj_r;
  assign prio_q      = prio_r;
  assign gx_q        = gx_r;
  assign rd_obj_out  = rd_obj_in | (hit_r ? obj_r : '0);
  assign rd_prio_out = rd_prio_in | (hit_r ? prio_r : '0);

  always_comb begin
    obj_nxt  = obj_r;
    prio_nxt = prio_r;
    case (ctl.mode)
      UPD_INSERT: begin
        if (f_le && !i_le_next) begin
          obj_nxt  = right_obj;
          prio_nxt = right_prio;
        end else if ((f_le && i_le_next && !i_le) || (!f_lt && i_le && !i_lt)) begin
          obj_nxt  = req_obj;
          prio_nxt = req_prio;
        end else if (i_lt && !f_lt) begin
          obj_nxt  = left_obj;
          prio_nxt = left_prio;
        end
      end
      UPD_REMOVE: begin
        if (IDX >= int'(req_pos)) begin
          obj_nxt  = right_obj;
          prio_nxt = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.eval_en) begin
      m_r   <= match;
      gx_r  <= occupied ? gt : 1'b1;
      hit_r <= IDX == int'(req_pos);
    end
    if (ctl.upd_en) begin
      obj_r  <= obj_nxt;
      prio_r <= prio_nxt;
    end
  end

endmodule

FILE: design/priority_ordered_list_unit.sv
// Priority-ordered list of up to DEPTH (object, priority) entries kept in falling
// priority, ties behind older entries. func selects insert (with an always, if-absent
// or if-present policy; an insert of a present object moves it), read at index or
// remove at index; every item gives exactly one result with a status, the read
// entry and the entry count after the operation. The list lives in a row of DEPTH
// cells that shift into their neighbors, so an operation costs the same at any
// fill level: one item takes three steps (accept, compare in every cell, shift
// and write the result register), and a new item is accepted in the cycle after
// the result register is loaded, even while that result is still stalled.
// Priorities are signed Q16.16; only the low PRIORITY_BITS and OBJECT_BITS are kept.
module priority_ordered_list_unit
  import pol_pkg::*;
#(
  parameter int DEPTH         = 32,
  parameter int OBJECT_BITS   = 16,
  parameter int PRIORITY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t               state_r, state_nxt;
  in_item_t             req_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_upd_r, count_upd_nxt;
  status_t              stat_r, stat_nxt;
  upd_mode_t            mode_r, mode_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 in_xfer, out_xfer, apply_go;
  logic                 found;
  cell_ctl_t            ctl;
  logic [OBJECT_BITS-1:0]   req_obj;
  logic [PRIORITY_BITS-1:0] req_prio;

  // chain wiring, padded so the ends see constant neighbors
  logic [OBJECT_BITS-1:0]   obj_pad  [DEPTH+2];
  logic [PRIORITY_BITS-1:0] prio_pad [DEPTH+2];
  logic                     gx_pad   [DEPTH+1];
  logic                     fb_ch    [DEPTH+1];
  logic                     ib_ch    [DEPTH+1];
  logic [OBJECT_BITS-1:0]   rdo_ch   [DEPTH+1];
  logic [PRIORITY_BITS-1:0] rdp_ch   [DEPTH+1];
  logic [DEPTH-1:0]         match_vec;

  // low bits of the request fields, zero extended where the storage is wider
  assign req_obj  = OBJECT_BITS'({48'b0, req_r.object_id});
  assign req_prio = PRIORITY_BITS'({32'b0, req_r.prio_in});

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign apply_go = (state_r == ST_APPLY) && (!out_valid_r || !out_stall);
  assign in_stall = state_r != ST_IDLE;

  assign ctl.eval_en = state_r == ST_EVAL;
  assign ctl.upd_en  = apply_go;
  assign ctl.mode    = mode_r;

  assign obj_pad[0]      = '0;
  assign prio_pad[0]     = '0;
  assign obj_pad[DEPTH+1]  = '0;
  assign prio_pad[DEPTH+1] = '0;
  assign gx_pad[DEPTH]   = 1'b1;
  assign fb_ch[0]        = 1'b0;
  assign ib_ch[0]        = 1'b0;
  assign rdo_ch[0]       = '0;
  assign rdp_ch[0]       = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pol_cell #(
      .IDX   (i),
      .OBJ_W (OBJECT_BITS),
      .PRIO_W(PRIORITY_BITS),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .req_obj    (req_obj),
      .req_prio   (req_prio),
      .req_pos    (req_r.position),
      .count      (count_r),
      .left_obj   (obj_pad[i]),
      .left_prio  (prio_pad[i]),
      .fb_in      (fb_ch[i]),
      .ib_in      (ib_ch[i]),
      .rd_obj_in  (rdo_ch[i]),
      .rd_prio_in (rdp_ch[i]),
      .right_obj  (obj_pad[i+2]),
      .right_prio (prio_pad[i+2]),
      .gx_right   (gx_pad[i+1]),
      .obj_q      (obj_pad[i+1]),
      .prio_q     (prio_pad[i+1]),
      .gx_q       (gx_pad[i]),
      .fb_out     (fb_ch[i+1]),
      .ib_out     (ib_ch[i+1]),
      .rd_obj_out (rdo_ch[i+1]),
      .rd_prio_out(rdp_ch[i+1]),
      .match      (match_vec[i])
    );
  end

  assign found = |match_vec;

  // decide status, cell update and new count while the cells compare
  always_comb begin
    stat_nxt      = STAT_OK;
    mode_nxt      = UPD_NONE;
    rd_ok_nxt     = 1'b0;
    count_upd_nxt = count_r;
    case (func_t'(req_r.func))
      FUNC_INSERT: begin
        if ((policy_t'(req_r.policy) == POL_ABSENT) && found) begin
          stat_nxt = STAT_REFUSED;
        end else if ((policy_t'(req_r.policy) == POL_PRESENT) && !found) begin
          stat_nxt = STAT_REFUSED;
        end else if (!found && (int'(count_r) >= DEPTH)) begin
          stat_nxt = STAT_FULL;
        end else begin
          mode_nxt = UPD_INSERT;
          if (!found) begin
            count_upd_nxt = count_r + 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (int'(req_r.position) >= int'(count_r)) begin
          stat_nxt = STAT_RANGE;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (int'(req_r.position) >= int'(count_r)) begin
          stat_nxt = STAT_RANGE;
        end else begin
          mode_nxt      = UPD_REMOVE;
          count_upd_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: accept, compare, apply
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= UPD_NONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EVAL) begin
        mode_r <= mode_nxt;
      end else if (apply_go) begin
        mode_r <= UPD_NONE;
      end
      if (apply_go) begin
        count_r     <= count_upd_r;
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (state_r == ST_EVAL) begin
      stat_r      <= stat_nxt;
      rd_ok_r     <= rd_ok_nxt;
      count_upd_r <= count_upd_nxt;
    end
    if (apply_go) begin
      out_data_r.status      <= stat_r;
      out_data_r.object_out  <= rd_ok_r ? 16'({48'b0, rdo_ch[DEPTH]}) : '0;
      out_data_r.prio_out    <= rd_ok_r ? 32'({32'b0, rdp_ch[DEPTH]}) : '0;
      out_data_r.entry_count <= 6'({8'b0, count_upd_r});
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/pol_checker.sv
module pol_checker
  import pol_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // only an ok status carries a read entry
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      (out_data.object_out == '0) && (out_data.prio_out == '0))
    else $error("read data on a failed operation");

  // a full refusal reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_FULL) |->
      (int'(out_data.entry_count) == (DEPTH % 64)))
    else $error("list full reported with a short count");

endmodule

bind priority_ordered_list_unit pol_checker #(.DEPTH(DEPTH)) u_pol_checker (.*);
